FILE: rtl/core/pph_pkg.sv
// pph_pkg: shared widths, payload structs, register codes and the control program
// for the pi position hold controller.
// No dependencies; used by pi_position_hold_top, pph_checker and tb.
package pph_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_W        = 16;
    localparam int STEP_W        = 10;
    localparam int ACC_W         = 33;
    localparam int DRIVE_W       = 8;
    localparam int ERR_W         = SAMPLE_BITS + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 33;
    localparam int MS_PER_SECOND = 1000;

    // sequencer sizing
    localparam int PROG_LEN = 12;
    localparam int STEP_CW  = 4;

    // register reset values
    localparam logic [STEP_W-1:0]         STEP_RESET = STEP_W'(20);
    localparam logic signed [DRIVE_W-1:0] DMIN_RESET = -DRIVE_W'(127);
    localparam logic signed [DRIVE_W-1:0] DMAX_RESET = DRIVE_W'(127);

    // input and result payloads
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] measured;
        logic [SAMPLE_BITS-1:0] setpoint;
        logic                   restart;
    } in_item_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      integral_clamped;
        logic                      drive_clamped;
    } out_item_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP   = 3'd0,
        CFG_KI   = 3'd1,
        CFG_STEP = 3'd2,
        CFG_IMIN = 3'd3,
        CFG_IMAX = 3'd4,
        CFG_DMIN = 3'd5,
        CFG_DMAX = 3'd6
    } cfg_reg_t;

    // datapath operation of one step
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_MUL,
        OP_FIX_Q,
        OP_FIX_C,
        OP_SUM,
        OP_CLAMP_I,
        OP_DRIVE,
        OP_EMIT
    } op_t;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MS_MAG_STEP,
        MS_P_M1,
        MS_R_M2,
        MS_KP_ERR,
        MS_KI_ACC
    } msel_t;

    // product destination
    typedef enum logic [2:0] {
        MD_P,
        MD_Q,
        MD_C,
        MD_T_LOAD,
        MD_T_ADD
    } mdst_t;

    // sequencing condition
    typedef enum logic [1:0] {
        CND_NEXT,
        CND_WAIT_IN,
        CND_WAIT_OUT,
        CND_JUMP
    } cond_t;

    typedef struct packed {
        op_t               op;
        msel_t             msel;
        mdst_t             mdst;
        cond_t             cond;
        logic [STEP_CW-1:0] target;
    } ctl_word_t;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // control program rom
    function automatic ctl_word_t ucode(input logic [STEP_CW-1:0] step);
        ctl_word_t w;
        w = '{op: OP_NOP, msel: MS_MAG_STEP, mdst: MD_P, cond: CND_NEXT, target: '0};
        unique case (step)
            4'd0: begin
                w.op   = OP_LOAD;
                w.cond = CND_WAIT_IN;
            end
            4'd1: begin
                w.op = OP_MUL; w.msel = MS_MAG_STEP; w.mdst = MD_P;
            end
            4'd2: begin
                w.op = OP_MUL; w.msel = MS_P_M1; w.mdst = MD_Q;
            end
            4'd3: w.op = OP_FIX_Q;
            4'd4: begin
                w.op = OP_MUL; w.msel = MS_R_M2; w.mdst = MD_C;
            end
            4'd5: w.op = OP_FIX_C;
            4'd6: w.op = OP_SUM;
            4'd7: w.op = OP_CLAMP_I;
            4'd8: begin
                w.op = OP_MUL; w.msel = MS_KP_ERR; w.mdst = MD_T_LOAD;
            end
            4'd9: begin
                w.op = OP_MUL; w.msel = MS_KI_ACC; w.mdst = MD_T_ADD;
            end
            4'd10: w.op = OP_DRIVE;
            4'd11: begin
                w.op   = OP_EMIT;
                w.cond = CND_WAIT_OUT;
            end
            default: begin
                w.cond = CND_JUMP;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/pi_position_hold_top.sv
// pi_position_hold_top: microcoded pi position controller with integral and drive clamps.
// Depends on pph_pkg (payload structs, register codes, control program).
//
// One input transfer is one control tick. A 12-step program in a read-only table runs
// the tick through one shared signed multiplier: the integral increment
// error*step_ms*2^FRAC_BITS/1000 is formed by two reciprocal multiplies with a
// compare-and-subtract fix, the integral is added and clamped, then
// kp*error*2^FRAC_BITS + ki*integral is accumulated, truncated toward zero and clamped.
// The five multiplies share the single multiplier. The steps run in order: load, two
// multiplies, quotient fix, multiply, fraction fix, add, clamp, two multiplies, drive
// and emit, which loads the result register. The next input can be taken in the cycle
// after the result is loaded, while the result waits in its output register.
// The last step holds only when the previous result is still untaken.
// Configuration writes are taken every cycle (cfg_ready is always high).
module pi_position_hold_top #(
    parameter int FRAC_BITS = pph_pkg::FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pph_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pph_pkg::out_item_t               m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pph_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pph_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int S_W     = pph_pkg::SAMPLE_BITS;
    localparam int ERR_W   = pph_pkg::ERR_W;
    localparam int STEP_W  = pph_pkg::STEP_W;
    localparam int GAIN_W  = pph_pkg::GAIN_W;
    localparam int ACC_W   = pph_pkg::ACC_W;
    localparam int DRIVE_W = pph_pkg::DRIVE_W;
    localparam int STEP_CW = pph_pkg::STEP_CW;

    // increment divider: P = mag*step, P = 1000*q + b, c = floor(b*2^F/1000)
    localparam int P_W  = S_W + STEP_W;
    localparam int K1   = P_W;
    localparam int Q_W  = P_W - 9;
    localparam logic [63:0] M1 = (64'd1 << K1) / 64'd1000;
    localparam int M1_W = K1 - 9;
    localparam int B_W  = 10;
    localparam int RS_W = B_W + FRAC_BITS;
    localparam int K2   = RS_W;
    localparam logic [63:0] M2 = (64'd1 << K2) / 64'd1000;
    localparam int M2_W = K2 - 9;
    localparam int C_W  = FRAC_BITS;
    localparam int R_W  = 11;
    localparam int INC_W = Q_W + FRAC_BITS;
    localparam int SUM_W = pph_pkg::imax(ACC_W, INC_W + 1) + 1;

    // shared multiplier
    localparam int MA_W = pph_pkg::imax(pph_pkg::imax(P_W + 1, RS_W + 1),
                                        pph_pkg::imax(ERR_W, ACC_W));
    localparam int MB_W = pph_pkg::imax(pph_pkg::imax(STEP_W + 1, M1_W + 1),
                                        pph_pkg::imax(M2_W + 1, GAIN_W));
    localparam int PR_W = MA_W + MB_W;

    // drive accumulator
    localparam int T_W   = pph_pkg::imax(GAIN_W + ERR_W + FRAC_BITS, GAIN_W + ACC_W) + 1;
    localparam int SHIFT = 8 + FRAC_BITS;
    localparam int DV_W  = T_W - SHIFT;

    // configuration registers
    logic signed [GAIN_W-1:0]  kp_reg, kp_next;
    logic signed [GAIN_W-1:0]  ki_reg, ki_next;
    logic [STEP_W-1:0]         step_ms_reg, step_ms_next;
    logic signed [ACC_W-1:0]   imin_reg, imin_next;
    logic signed [ACC_W-1:0]   imax_reg, imax_next;
    logic signed [DRIVE_W-1:0] dmin_reg, dmin_next;
    logic signed [DRIVE_W-1:0] dmax_reg, dmax_next;

    // sequencer and state
    logic [STEP_CW-1:0]        pc_reg, pc_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic                      m_valid_reg, m_valid_next;
    pph_pkg::out_item_t        out_reg, out_next;

    // datapath working registers
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [S_W-1:0]            mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic [P_W-1:0]            p_reg, p_next;
    logic [Q_W-1:0]            q_reg, q_next;
    logic [B_W-1:0]            b_reg, b_next;
    logic [C_W-1:0]            c_reg, c_next;
    logic signed [INC_W:0]     inc_reg, inc_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      icl_reg, icl_next;
    logic signed [T_W-1:0]     t_reg, t_next;
    logic signed [DV_W-1:0]    dv_reg, dv_next;

    pph_pkg::ctl_word_t        cw;
    logic                      go;
    logic signed [MA_W-1:0]    ma;
    logic signed [MB_W-1:0]    mb;
    logic signed [PR_W-1:0]    prod;

    // combinational temporaries
    logic [P_W-1:0]            qk;
    logic [R_W-1:0]            rq;
    logic [RS_W-1:0]           rs;
    logic [RS_W-1:0]           ck;
    logic [R_W-1:0]            rc;
    logic [C_W-1:0]            c_fix;
    logic signed [INC_W:0]     inc_mag;
    logic signed [DV_W-1:0]    dv_floor;

    assign cw        = pph_pkg::ucode(pc_reg);
    assign s_ready   = (cw.cond == pph_pkg::CND_WAIT_IN);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // step counter and branch conditions
    always_comb begin
        go      = 1'b1;
        pc_next = STEP_CW'(pc_reg + 1'b1);
        unique case (cw.cond)
            pph_pkg::CND_NEXT: begin
                go = 1'b1;
            end
            pph_pkg::CND_WAIT_IN: begin
                go = s_valid;
                if (!s_valid) begin
                    pc_next = pc_reg;
                end
            end
            pph_pkg::CND_WAIT_OUT: begin
                go = !m_valid_reg || m_ready;
                pc_next = go ? cw.target : pc_reg;
            end
            pph_pkg::CND_JUMP: begin
                go      = 1'b1;
                pc_next = cw.target;
            end
            default: begin
                go      = 1'b0;
                pc_next = '0;
            end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (cw.msel)
            pph_pkg::MS_MAG_STEP: begin
                ma = MA_W'(mag_reg);
                mb = MB_W'(step_ms_reg);
            end
            pph_pkg::MS_P_M1: begin
                ma = MA_W'(p_reg);
                mb = MB_W'(M1);
            end
            pph_pkg::MS_R_M2: begin
                ma = MA_W'({b_reg, {FRAC_BITS{1'b0}}});
                mb = MB_W'(M2);
            end
            pph_pkg::MS_KP_ERR: begin
                ma = MA_W'(err_reg);
                mb = MB_W'(kp_reg);
            end
            pph_pkg::MS_KI_ACC: begin
                ma = MA_W'(acc_reg);
                mb = MB_W'(ki_reg);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    // remainder fix after the reciprocal multiplies
    always_comb begin
        qk       = P_W'(q_reg) * P_W'(pph_pkg::MS_PER_SECOND);
        rq       = R_W'(p_reg - qk);
        rs       = {b_reg, {FRAC_BITS{1'b0}}};
        ck       = RS_W'(c_reg) * RS_W'(pph_pkg::MS_PER_SECOND);
        rc       = R_W'(rs - ck);
        c_fix    = c_reg + C_W'(rc >= R_W'(pph_pkg::MS_PER_SECOND));
        inc_mag  = (INC_W + 1)'({q_reg, c_fix});
        dv_floor = DV_W'(t_reg >>> SHIFT);
    end

    // datapath and configuration next state
    always_comb begin
        kp_next      = kp_reg;
        ki_next      = ki_reg;
        step_ms_next = step_ms_reg;
        imin_next    = imin_reg;
        imax_next    = imax_reg;
        dmin_next    = dmin_reg;
        dmax_next    = dmax_reg;
        acc_next     = acc_reg;
        out_next     = out_reg;
        err_next     = err_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        inc_next     = inc_reg;
        sum_next     = sum_reg;
        icl_next     = icl_reg;
        t_next       = t_reg;
        dv_next      = dv_reg;
        m_valid_next = m_valid_reg && !m_ready;

        // configuration write transfer
        if (cfg_valid) begin
            unique case (cfg_index)
                pph_pkg::CFG_KP:   kp_next      = GAIN_W'(cfg_data);
                pph_pkg::CFG_KI:   ki_next      = GAIN_W'(cfg_data);
                pph_pkg::CFG_STEP: step_ms_next = STEP_W'(cfg_data);
                pph_pkg::CFG_IMIN: imin_next    = ACC_W'(cfg_data);
                pph_pkg::CFG_IMAX: imax_next    = ACC_W'(cfg_data);
                pph_pkg::CFG_DMIN: dmin_next    = DRIVE_W'(cfg_data);
                pph_pkg::CFG_DMAX: dmax_next    = DRIVE_W'(cfg_data);
                default: ;
            endcase
        end

        if (go) begin
            unique case (cw.op)
                pph_pkg::OP_NOP: ;
                // input transfer: error, magnitude, restart
                pph_pkg::OP_LOAD: begin
                    err_next = ERR_W'({1'b0, s_data.setpoint}) - ERR_W'({1'b0, s_data.measured});
                    neg_next = err_next[ERR_W-1];
                    mag_next = S_W'(neg_next ? -err_next : err_next);
                    if (s_data.restart) begin
                        acc_next = '0;
                    end
                end
                pph_pkg::OP_MUL: begin
                    unique case (cw.mdst)
                        pph_pkg::MD_P:      p_next = P_W'(prod);
                        pph_pkg::MD_Q:      q_next = prod[K1 +: Q_W];
                        pph_pkg::MD_C:      c_next = prod[K2 +: C_W];
                        pph_pkg::MD_T_LOAD: t_next = T_W'(prod) <<< FRAC_BITS;
                        pph_pkg::MD_T_ADD:  t_next = t_reg + T_W'(prod);
                        default: ;
                    endcase
                end
                // quotient may be one short
                pph_pkg::OP_FIX_Q: begin
                    if (rq >= R_W'(pph_pkg::MS_PER_SECOND)) begin
                        q_next = q_reg + 1'b1;
                        b_next = B_W'(rq - R_W'(pph_pkg::MS_PER_SECOND));
                    end else begin
                        b_next = B_W'(rq);
                    end
                end
                // fractional part fix and sign
                pph_pkg::OP_FIX_C: begin
                    inc_next = neg_reg ? -inc_mag : inc_mag;
                end
                pph_pkg::OP_SUM: begin
                    sum_next = SUM_W'(acc_reg) + SUM_W'(inc_reg);
                end
                // upper limit is tested first, so it wins when the limits cross and the sum is above it
                pph_pkg::OP_CLAMP_I: begin
                    if (sum_reg > SUM_W'(imax_reg)) begin
                        acc_next = imax_reg;
                        icl_next = 1'b1;
                    end else if (sum_reg < SUM_W'(imin_reg)) begin
                        acc_next = imin_reg;
                        icl_next = 1'b1;
                    end else begin
                        acc_next = ACC_W'(sum_reg);
                        icl_next = 1'b0;
                    end
                end
                // truncate toward zero
                pph_pkg::OP_DRIVE: begin
                    dv_next = dv_floor + DV_W'(t_reg[T_W-1] && (|t_reg[SHIFT-1:0]));
                end
                // drive clamp and result register load
                pph_pkg::OP_EMIT: begin
                    m_valid_next              = 1'b1;
                    out_next.integral_clamped = icl_reg;
                    if (dv_reg > DV_W'(dmax_reg)) begin
                        out_next.drive         = dmax_reg;
                        out_next.drive_clamped = 1'b1;
                    end else if (dv_reg < DV_W'(dmin_reg)) begin
                        out_next.drive         = dmin_reg;
                        out_next.drive_clamped = 1'b1;
                    end else begin
                        out_next.drive         = DRIVE_W'(dv_reg);
                        out_next.drive_clamped = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            kp_reg      <= '0;
            ki_reg      <= '0;
            step_ms_reg <= pph_pkg::STEP_RESET;
            imin_reg    <= '0;
            imax_reg    <= '0;
            dmin_reg    <= pph_pkg::DMIN_RESET;
            dmax_reg    <= pph_pkg::DMAX_RESET;
        end else begin
            pc_reg      <= pc_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            kp_reg      <= kp_next;
            ki_reg      <= ki_next;
            step_ms_reg <= step_ms_next;
            imin_reg    <= imin_next;
            imax_reg    <= imax_next;
            dmin_reg    <= dmin_next;
            dmax_reg    <= dmax_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        err_reg <= err_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        inc_reg <= inc_next;
        sum_reg <= sum_next;
        icl_reg <= icl_next;
        t_reg   <= t_next;
        dv_reg  <= dv_next;
    end

    // one tick at a time: no input transfer right after another
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a tick is in progress");

    // a result appears only from the emit step
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cw.op == pph_pkg::OP_EMIT))
        else $error("result valid without emit step");

    // integral lands inside ordered limits after its clamp step
    a_acc_in_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cw.op == pph_pkg::OP_CLAMP_I) && ($past(imin_reg) <= $past(imax_reg))
        |-> (acc_reg >= $past(imin_reg)) && (acc_reg <= $past(imax_reg)))
        else $error("integral outside its limits after clamp");

endmodule

FILE: test/pph_checker.sv
// pph_checker: scoreboard for pi_position_hold_top; watches the input, result and
// register channels, predicts each control tick and compares the results in order.
// Depends on pph_pkg (payload structs, widths, register codes).
module pph_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  pph_pkg::in_item_t              s_data,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  pph_pkg::out_item_t             m_data,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [pph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pph_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             drives_checked,
    output int                             drives_pending
);
    import pph_pkg::*;

    localparam longint UNITY = longint'(1) << FRAC_BITS;

    // controller settings and integrator as the block should hold them
    logic signed [GAIN_W-1:0]  kp_gain;
    logic signed [GAIN_W-1:0]  ki_gain;
    logic [STEP_W-1:0]         tick_ms;
    logic signed [ACC_W-1:0]   acc_lo;
    logic signed [ACC_W-1:0]   acc_hi;
    logic signed [DRIVE_W-1:0] drv_lo;
    logic signed [DRIVE_W-1:0] drv_hi;
    logic signed [ACC_W-1:0]   integ;
    out_item_t                 drive_q[$];
    int                        bad_count  = 0;
    int                        seen_count = 0;

    // one control tick: integrate, clamp, form the drive, clamp
    function automatic out_item_t next_drive(input in_item_t tick);
        longint    err;
        longint    mag;
        longint    incr;
        longint    sum;
        longint    total;
        longint    drv;
        out_item_t res;
        res = '0;
        if (tick.restart) begin
            integ = '0;
        end
        err  = longint'(tick.setpoint) - longint'(tick.measured);
        mag  = (err < 0) ? -err : err;
        incr = (mag * longint'(tick_ms) * UNITY) / longint'(MS_PER_SECOND);
        if (err < 0) begin
            incr = -incr;
        end
        // upper limit is tested first, so a sum above both swapped limits resolves to the upper one
        sum = longint'(integ) + incr;
        if (sum > longint'(acc_hi)) begin
            sum = longint'(acc_hi);
            res.integral_clamped = 1'b1;
        end else if (sum < longint'(acc_lo)) begin
            sum = longint'(acc_lo);
            res.integral_clamped = 1'b1;
        end
        integ = ACC_W'(sum);
        // truncate toward zero first, then clamp the integer drive
        total = longint'(kp_gain) * err * UNITY + longint'(ki_gain) * longint'(integ);
        drv   = total / (UNITY * 256);
        if (drv > longint'(drv_hi)) begin
            drv = longint'(drv_hi);
            res.drive_clamped = 1'b1;
        end else if (drv < longint'(drv_lo)) begin
            drv = longint'(drv_lo);
            res.drive_clamped = 1'b1;
        end
        res.drive = DRIVE_W'(drv);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            kp_gain = '0;
            ki_gain = '0;
            tick_ms = STEP_RESET;
            acc_lo  = '0;
            acc_hi  = '0;
            drv_lo  = DMIN_RESET;
            drv_hi  = DMAX_RESET;
            integ   = '0;
            drive_q.delete();
        end else begin
            // result transfer against the oldest prediction, shown as drive/ic/dc
            if (m_valid && m_ready) begin
                seen_count++;
                if (drive_q.size() == 0) begin
                    bad_count++;
                    $display("%0t: unexpected result: expected none, actual %0d/%0b/%0b",
                             $time, m_data.drive, m_data.integral_clamped,
                             m_data.drive_clamped);
                end else begin
                    want = drive_q.pop_front();
                    if (want.drive !== m_data.drive ||
                        want.integral_clamped !== m_data.integral_clamped ||
                        want.drive_clamped !== m_data.drive_clamped) begin
                        bad_count++;
                        $display("%0t: mismatch: expected %0d/%0b/%0b, actual %0d/%0b/%0b",
                                 $time, want.drive, want.integral_clamped,
                                 want.drive_clamped, m_data.drive,
                                 m_data.integral_clamped, m_data.drive_clamped);
                    end
                end
            end
            // register write, unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_KP:   kp_gain = cfg_data[GAIN_W-1:0];
                    CFG_KI:   ki_gain = cfg_data[GAIN_W-1:0];
                    CFG_STEP: tick_ms = cfg_data[STEP_W-1:0];
                    CFG_IMIN: acc_lo  = cfg_data[ACC_W-1:0];
                    CFG_IMAX: acc_hi  = cfg_data[ACC_W-1:0];
                    CFG_DMIN: drv_lo  = cfg_data[DRIVE_W-1:0];
                    CFG_DMAX: drv_hi  = cfg_data[DRIVE_W-1:0];
                    default: ;
                endcase
            end
            // input transfer, predict its result
            if (s_valid && s_ready) begin
                drive_q.push_back(next_drive(s_data));
            end
        end
        mismatch_count <= bad_count;
        drives_checked <= seen_count;
        drives_pending <= drive_q.size();
    end

endmodule

FILE: test/tb.sv
// tb: top of the pi_position_hold_top bench; makes clock, reset, register setups,
// directed and random control ticks with random idling, and gives the verdict.
// Depends on pph_pkg, pi_position_hold_top and pph_checker.
module tb;
    import pph_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_PHASES   = 10;
    localparam int TICKS_PER_PHASE = 110;
    localparam int HOLD_AFTER      = 400;
    localparam int LONG_HOLD       = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int TAIL_CYCLES     = 40;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int drives_checked;
    int drives_pending;
    int sent_count   = 0;
    int setup_count  = 0;
    int tx_idle_pct  = 20;
    int rx_idle_pct  = 20;
    int stuck_cycles = 0;
    bit hold_done    = 1'b0;

    pi_position_hold_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pph_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .drives_checked (drives_checked),
        .drives_pending (drives_pending)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL pi_position_hold_top");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // result side: random stall bursts, one long hold-off while ticks keep coming
    initial begin : result_side
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && sent_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if ($urandom_range(1, 100) <= rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    // one register write, held until the transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // one control tick, with an optional idle burst ahead of it
    task automatic send_tick(input int meas, input int target, input bit restart);
        in_item_t tick;
        tick.measured = SAMPLE_BITS'(meas);
        tick.setpoint = SAMPLE_BITS'(target);
        tick.restart  = restart;
        if ($urandom_range(1, 100) <= tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= tick;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // block is idle once every predicted result has come back
    task automatic wait_idle();
        do @(posedge aclk); while (drives_pending != 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return CFG_DATA_W'(16'h8000);
            1:       return CFG_DATA_W'(16'h7FFF);
            2:       return CFG_DATA_W'(GAIN_W'($urandom_range(0, 1024) - 512));
            3:       return CFG_DATA_W'($urandom_range(64, 512));
            default: return CFG_DATA_W'(GAIN_W'($urandom));
        endcase
    endfunction

    // random register setup, extremes and swapped limits included
    task automatic load_random_setup();
        int span;
        int lo;
        int hi;
        logic [CFG_DATA_W-1:0] ilo;
        logic [CFG_DATA_W-1:0] ihi;
        write_reg(CFG_KP, pick_gain());
        write_reg(CFG_KI, pick_gain());
        case ($urandom_range(0, 5))
            0:       write_reg(CFG_STEP, CFG_DATA_W'(0));
            1:       write_reg(CFG_STEP, CFG_DATA_W'(1023));
            2:       write_reg(CFG_STEP, CFG_DATA_W'(1));
            3:       write_reg(CFG_STEP, CFG_DATA_W'(1000));
            default: write_reg(CFG_STEP, CFG_DATA_W'($urandom_range(1, 1000)));
        endcase
        span = int'($urandom_range(0, 1 << 24));
        case ($urandom_range(0, 4))
            0: begin
                ilo = 33'h1_0000_0000;
                ihi = 33'h0_FFFF_FFFF;
            end
            1: begin
                ilo = CFG_DATA_W'(-span);
                ihi = CFG_DATA_W'(span);
            end
            2: begin
                ilo = CFG_DATA_W'({$urandom, $urandom});
                ihi = CFG_DATA_W'({$urandom, $urandom});
            end
            3: begin
                ilo = CFG_DATA_W'(span);
                ihi = CFG_DATA_W'(-span);
            end
            default: begin
                ilo = '0;
                ihi = '0;
            end
        endcase
        write_reg(CFG_IMIN, ilo);
        write_reg(CFG_IMAX, ihi);
        lo = int'($urandom_range(0, 255)) - 128;
        hi = int'($urandom_range(0, 255)) - 128;
        case ($urandom_range(0, 3))
            0: begin
                lo = -127;
                hi = 127;
            end
            1: begin
                lo = -128;
                hi = 127;
            end
            2: begin
                if (lo > hi) begin
                    span = lo;
                    lo   = hi;
                    hi   = span;
                end
            end
            default: ;
        endcase
        write_reg(CFG_DMIN, CFG_DATA_W'(lo));
        write_reg(CFG_DMAX, CFG_DATA_W'(hi));
        cfg_valid <= 1'b0;
        setup_count++;
    endtask

    initial begin : stimulus
        int meas;
        int target;
        int directed_count;
        bit push_up;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // drive limits at both ends incl. -128, exact drive limits, zero step
        write_reg(CFG_KP, CFG_DATA_W'(256));
        write_reg(CFG_KI, CFG_DATA_W'(0));
        write_reg(CFG_STEP, CFG_DATA_W'(0));
        write_reg(CFG_IMIN, 33'h1_0000_0000);
        write_reg(CFG_IMAX, 33'h0_FFFF_FFFF);
        write_reg(CFG_DMIN, CFG_DATA_W'(-128));
        write_reg(CFG_DMAX, CFG_DATA_W'(127));
        write_reg(CFG_UNUSED, '1);
        cfg_valid <= 1'b0;
        setup_count++;
        send_tick(0, SAMPLE_MAX, 1'b1);
        send_tick(SAMPLE_MAX, 0, 1'b0);
        send_tick(1000, 1127, 1'b0);
        send_tick(1128, 1000, 1'b0);
        send_tick(2048, 2048, 1'b0);
        s_valid <= 1'b0;

        // gain extremes, out-of-range step, integral limits swapped
        wait_idle();
        write_reg(CFG_KP, CFG_DATA_W'(16'h8000));
        write_reg(CFG_KI, CFG_DATA_W'(16'h7FFF));
        write_reg(CFG_STEP, CFG_DATA_W'(1023));
        write_reg(CFG_IMIN, CFG_DATA_W'(5000));
        write_reg(CFG_IMAX, CFG_DATA_W'(-5000));
        cfg_valid <= 1'b0;
        setup_count++;
        send_tick(0, 1, 1'b1);
        send_tick(1, 0, 1'b0);
        send_tick(2000, 2000, 1'b1);
        send_tick(SAMPLE_MAX, 0, 1'b0);
        s_valid <= 1'b0;

        // integral landing exactly on its limits, drive truncated before the clamp
        wait_idle();
        write_reg(CFG_KP, CFG_DATA_W'(16'h7FFF));
        write_reg(CFG_KI, CFG_DATA_W'(16'h8000));
        write_reg(CFG_STEP, CFG_DATA_W'(1000));
        write_reg(CFG_IMIN, CFG_DATA_W'(0));
        write_reg(CFG_IMAX, CFG_DATA_W'(65536));
        write_reg(CFG_DMIN, CFG_DATA_W'(-127));
        cfg_valid <= 1'b0;
        setup_count++;
        send_tick(10, 11, 1'b1);
        send_tick(11, 10, 1'b0);
        send_tick(11, 10, 1'b0);
        send_tick(0, SAMPLE_MAX, 0);
        s_valid <= 1'b0;

        // negative increment truncation, drive limits swapped
        wait_idle();
        write_reg(CFG_KP, CFG_DATA_W'(128));
        write_reg(CFG_KI, CFG_DATA_W'(256));
        write_reg(CFG_STEP, CFG_DATA_W'(1));
        write_reg(CFG_IMIN, 33'h1_0000_0000);
        write_reg(CFG_IMAX, 33'h0_FFFF_FFFF);
        write_reg(CFG_DMIN, CFG_DATA_W'(20));
        write_reg(CFG_DMAX, CFG_DATA_W'(-20));
        cfg_valid <= 1'b0;
        setup_count++;
        send_tick(5, 4, 1'b1);
        send_tick(4, 5, 1'b0);
        send_tick(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_tick(0, 0, 1'b0);
        send_tick(0, SAMPLE_MAX, 1'b0);
        s_valid <= 1'b0;
        directed_count = sent_count;

        // random phases, each with its own setup and idling mix
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            load_random_setup();
            push_up = 1'($urandom_range(0, 1));
            if (ph == 0 || ph == RANDOM_PHASES - 1) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 20 * int'($urandom_range(0, 3));
                rx_idle_pct = 20 * int'($urandom_range(0, 3));
            end
            for (int n = 0; n < TICKS_PER_PHASE; n++) begin
                meas = int'($urandom_range(0, SAMPLE_MAX));
                case ($urandom_range(0, 3))
                    0: begin
                        target = meas + int'($urandom_range(0, 16)) - 8;
                        if (target < 0) target = 0;
                        if (target > SAMPLE_MAX) target = SAMPLE_MAX;
                    end
                    1: target = int'($urandom_range(0, SAMPLE_MAX));
                    default: begin
                        // steady push so the integrator runs into its limits
                        if (push_up) begin
                            meas   = int'($urandom_range(0, 64));
                            target = int'($urandom_range(SAMPLE_MAX - 95, SAMPLE_MAX));
                        end else begin
                            meas   = int'($urandom_range(SAMPLE_MAX - 64, SAMPLE_MAX));
                            target = int'($urandom_range(0, 95));
                        end
                    end
                endcase
                send_tick(meas, target, $urandom_range(0, 24) == 0);
            end
            s_valid <= 1'b0;
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d control ticks (%0d directed) over %0d register setups",
                 sent_count, directed_count, setup_count);
        $display("%0d results compared, %0d mismatches, %0d still outstanding",
                 drives_checked, mismatch_count, drives_pending);
        if (mismatch_count == 0 && drives_pending == 0) begin
            $display("PASS pi_position_hold_top");
        end else begin
            $display("FAIL pi_position_hold_top");
        end
        $finish;
    end

endmodule
